// ----- sv/dcq_pkg.sv -----
// dcq_pkg: constants, codes and shared types of the dual circular queue.
// Used by the channel interfaces, the controller, the datapath and the top level.
package dcq_pkg;

  localparam int TOTAL_DEPTH = 128;
  localparam int HALF        = TOTAL_DEPTH / 2;
  localparam int ADDR_W      = $clog2(TOTAL_DEPTH);
  localparam int PTR_W       = $clog2(HALF);
  localparam int CNT_W       = $clog2(HALF + 1);
  localparam int WORD_W      = 32;

  // command field
  localparam logic CMD_ENQ = 1'b0;
  localparam logic CMD_DEQ = 1'b1;

  // status field
  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_FULL  = 2'd1;
  localparam logic [1:0] STATUS_EMPTY = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_READ
  } state_t;

  // controller -> datapath
  typedef struct packed {
    logic take;         // word accepted: update pointers, write or read memory
    logic load_direct;  // load result register from the accepted word
    logic load_mem;     // load result register from memory read data
  } dcq_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic sel_full;
    logic sel_empty;
    logic res_busy;     // result register holds a word that is not taken this cycle
  } dcq_stat_t;

endpackage

// ----- sv/dcq_in_if.sv -----
// dcq_in_if: request channel (valid/ready plus command, queue select and push value).
// Depends on dcq_pkg for the word width.
interface dcq_in_if import dcq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic                     cmd;
  logic                     queue_sel;
  logic signed [WORD_W-1:0] push_value;

  modport source (output valid, cmd, queue_sel, push_value, input ready);
  modport sink   (input valid, cmd, queue_sel, push_value, output ready);
endinterface

// ----- sv/dcq_out_if.sv -----
// dcq_out_if: result channel (valid/ready plus popped value and status).
// Depends on dcq_pkg for the word width.
interface dcq_out_if import dcq_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [WORD_W-1:0] pop_value;
  logic [1:0]               status;

  modport source (output valid, pop_value, status, input ready);
  modport sink   (input valid, pop_value, status, output ready);
endinterface

// ----- sv/dcq_ctrl.sv -----
// dcq_ctrl: controller state machine of the dual circular queue.
// Depends on dcq_pkg (state_t, dcq_cmd_t, dcq_stat_t, command codes).
module dcq_ctrl import dcq_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  input  logic      in_cmd,
  input  dcq_stat_t stat,
  output logic      in_ready,
  output dcq_cmd_t  cmd
);

  state_t state, state_next;
  logic   accept;
  logic   mem_pop;

  assign accept  = in_valid && in_ready;
  // a dequeue of a non-empty queue waits in ST_READ for the registered read
  assign mem_pop = (in_cmd == CMD_DEQ) && !stat.sel_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept && mem_pop) state_next = ST_READ;
      end
      ST_READ: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready        = 1'b0;
    cmd.take        = 1'b0;
    cmd.load_direct = 1'b0;
    cmd.load_mem    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready        = !stat.res_busy;
        cmd.take        = accept;
        cmd.load_direct = accept && !mem_pop;
      end
      ST_READ: cmd.load_mem = 1'b1;
      default: ;
    endcase
  end

endmodule

// ----- sv/dcq_dpath.sv -----
// dcq_dpath: shared storage, per-queue head/tail/count and the result register.
// Depends on dcq_pkg (sizes, codes, dcq_cmd_t, dcq_stat_t).
module dcq_dpath import dcq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  dcq_cmd_t                 cmd,
  input  logic                     in_cmd,
  input  logic                     in_sel,
  input  logic signed [WORD_W-1:0] push_value,
  input  logic                     out_ready,
  output dcq_stat_t                stat,
  output logic                     res_valid,
  output logic signed [WORD_W-1:0] pop_value,
  output logic [1:0]               status
);

  localparam logic [ADDR_W-1:0] HALF_BASE = ADDR_W'(HALF);
  localparam logic [PTR_W-1:0]  PTR_LAST  = PTR_W'(HALF - 1);
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(HALF);

  logic [WORD_W-1:0] mem [TOTAL_DEPTH];
  logic [WORD_W-1:0] rdata;

  logic [PTR_W-1:0] head [2];
  logic [PTR_W-1:0] tail [2];
  logic [CNT_W-1:0] count [2];

  logic [PTR_W-1:0]  head_sel, tail_sel;
  logic [ADDR_W-1:0] base, wr_addr, rd_addr;
  logic              do_write, do_read;

  assign head_sel = head[in_sel];
  assign tail_sel = tail[in_sel];
  assign base     = in_sel ? HALF_BASE : '0;
  assign wr_addr  = base + ADDR_W'(tail_sel);
  assign rd_addr  = base + ADDR_W'(head_sel);

  assign stat.sel_full  = (count[in_sel] == CNT_FULL);
  assign stat.sel_empty = (count[in_sel] == '0);
  assign stat.res_busy  = res_valid && !out_ready;

  assign do_write = cmd.take && (in_cmd == CMD_ENQ) && !stat.sel_full;
  assign do_read  = cmd.take && (in_cmd == CMD_DEQ) && !stat.sel_empty;

  always_ff @(posedge clk) begin
    if (do_write) mem[wr_addr] <= push_value;
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 2; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        count[i] <= '0;
      end
    end else if (do_write) begin
      tail[in_sel]  <= (tail_sel == PTR_LAST) ? '0 : tail_sel + PTR_W'(1);
      count[in_sel] <= count[in_sel] + CNT_W'(1);
    end else if (do_read) begin
      head[in_sel]  <= (head_sel == PTR_LAST) ? '0 : head_sel + PTR_W'(1);
      count[in_sel] <= count[in_sel] - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.load_direct || cmd.load_mem) begin
      res_valid <= 1'b1;
    end else if (out_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_mem) begin
      pop_value <= rdata;
      status    <= STATUS_OK;
    end else if (cmd.load_direct) begin
      if (in_cmd == CMD_DEQ) begin
        pop_value <= '1;
        status    <= STATUS_EMPTY;
      end else begin
        pop_value <= '0;
        status    <= stat.sel_full ? STATUS_FULL : STATUS_OK;
      end
    end
  end

endmodule

// ----- sv/dual_circular_queue_core.sv -----
// dual_circular_queue_core: two FIFO queues sharing one 128-word memory.
// Depends on dcq_pkg, dcq_in_if, dcq_out_if, dcq_ctrl and dcq_dpath.
//
//   channel  dir  signals                                  word
//   item     in   valid, ready, cmd, queue_sel, push_value one enqueue or dequeue
//   result   out  valid, ready, pop_value, status          one per item
//
// Enqueue and refused items load the result register directly; a dequeue that pops
// passes through ST_READ, due to the registered read port of the storage memory.
// The result register holds a word until taken; a new item is taken in the same
// cycle the previous result leaves. Synchronous reset empties both queues;
// storage contents are not cleared and need no clearing pass.
module dual_circular_queue_core import dcq_pkg::*; (
  input logic  clk,
  input logic  rst,
  dcq_in_if.sink    item,
  dcq_out_if.source result
);

  dcq_cmd_t  cmd;
  dcq_stat_t stat;
  logic      res_valid;

  dcq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (item.valid),
    .in_cmd   (item.cmd),
    .stat     (stat),
    .in_ready (item.ready),
    .cmd      (cmd)
  );

  dcq_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .in_cmd     (item.cmd),
    .in_sel     (item.queue_sel),
    .push_value (item.push_value),
    .out_ready  (result.ready),
    .stat       (stat),
    .res_valid  (res_valid),
    .pop_value  (result.pop_value),
    .status     (result.status)
  );

  assign result.valid = res_valid;

  a_no_take_in_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load_mem |-> !item.ready && !cmd.take)
    else $error("item taken while a memory pop is in flight");

  a_load_exclusive: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_direct && cmd.load_mem))
    else $error("result loaded from two sources");

  a_pop_follows: assert property (@(posedge clk) disable iff (rst)
    cmd.take && !cmd.load_direct |=> cmd.load_mem)
    else $error("dequeue did not load read data");

  // a popping dequeue has its result loaded in the next cycle
  a_take_has_result: assert property (@(posedge clk) disable iff (rst)
    cmd.take |=> (result.valid || cmd.load_mem))
    else $error("accepted item produced no result");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.status == STATUS_OK || result.status == STATUS_FULL ||
                      result.status == STATUS_EMPTY))
    else $error("bad status code");

endmodule
